// ===== rtl/ifp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg - shared types and constants of the IMU frame parser
// Frame markers, type codes, register indexes and the records that travel
// between the frame assembler, the frame queue and the scaling back end.
// ----------------------------------------------------------------------------
package ifp_pkg;

   // frame layout
   localparam logic [7:0] FRAME_START = 8'h55;
   localparam logic [3:0] LAST_COUNT  = 4'd10;   // position of the checksum byte
   localparam int         FRAME_SLOTS = 10;

   // type bytes
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;

   // configuration registers
   localparam int CSR_ADDR_W = 2;
   localparam int SCALE_W    = 28;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEL_FS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GYRO_FS  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_FS = 2'd2;
   localparam logic [SCALE_W-1:0] ACCEL_FS_RESET = 28'd10276045;
   localparam logic [SCALE_W-1:0] GYRO_FS_RESET  = 28'd131072000;
   localparam logic [SCALE_W-1:0] ANGLE_FS_RESET = 28'd11796480;

   // frame queue depth between front and back
   localparam int DESC_DEPTH = 2;

   // temperature: floor(m / 100) = (m * TEMP_RECIP) >> TEMP_SHIFT for m < 2^32
   localparam logic [31:0] TEMP_RECIP = 32'd2748779070;
   localparam int          TEMP_SHIFT = 38;

   // result field widths
   localparam int AXIS_W = 29;
   localparam int TEMP_W = 26;

   typedef enum logic [1:0] {
      KIND_ACCEL = 2'd0,
      KIND_GYRO  = 2'd1,
      KIND_ANGLE = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   // one checked frame, raw words little-endian already assembled
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  type_byte;
      logic [15:0] raw_x;
      logic [15:0] raw_y;
      logic [15:0] raw_z;
      logic [15:0] raw_w;
   } desc_type;

   // front end output toward the frame queue
   typedef struct packed {
      logic     push;
      desc_type desc;
   } front_out_type;

   // one finished result word
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         type_byte;
      logic [AXIS_W-1:0]  axis_x;
      logic [AXIS_W-1:0]  axis_y;
      logic [AXIS_W-1:0]  axis_z;
      logic [TEMP_W-1:0]  temperature;
      logic               temp_valid;
      logic [15:0]        version_word;
   } rsp_type;

endpackage

// ===== rtl/ifp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_front - frame assembler
// Hunts for the start byte, collects the frame, keeps a running checksum and
// hands each good frame, already classified, to the frame queue.
// ----------------------------------------------------------------------------
module ifp_front
   import ifp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  logic [7:0]    req_rx_byte,
   output logic          req_full,
   input  logic          desc_full,
   output front_out_type front_out
);

   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] bytes_ff [FRAME_SLOTS];
   logic       accept;
   logic       good;
   kind_type   kind;

   // stall only on the checksum byte, and only if the queue has no room
   assign req_full = (cnt_ff == LAST_COUNT) && desc_full;
   assign accept   = req_push && !req_full;

   // byte counter and running checksum
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      good   = 1'b0;
      if (accept) begin
         if (cnt_ff == 4'd0) begin
            if (req_rx_byte == FRAME_START) begin
               cnt_in = 4'd1;
               sum_in = req_rx_byte;
            end
         end else if (cnt_ff == LAST_COUNT) begin
            cnt_in = 4'd0;
            sum_in = 8'd0;
            good   = (req_rx_byte == sum_ff);
         end else begin
            cnt_in = cnt_ff + 4'd1;
            sum_in = sum_ff + req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
         sum_ff <= 8'd0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end

   // frame body, one slot per position
   always_ff @(posedge clock) begin
      if (accept && (cnt_ff != LAST_COUNT)) begin
         bytes_ff[cnt_ff] <= req_rx_byte;
      end
   end

   // classify by type byte
   always_comb begin
      unique case (bytes_ff[1])
         TYPE_ACCEL: kind = KIND_ACCEL;
         TYPE_GYRO:  kind = KIND_GYRO;
         TYPE_ANGLE: kind = KIND_ANGLE;
         default:    kind = KIND_OTHER;
      endcase
   end

   assign front_out.push           = good;
   assign front_out.desc.kind      = kind;
   assign front_out.desc.type_byte = bytes_ff[1];
   assign front_out.desc.raw_x     = {bytes_ff[3], bytes_ff[2]};
   assign front_out.desc.raw_y     = {bytes_ff[5], bytes_ff[4]};
   assign front_out.desc.raw_z     = {bytes_ff[7], bytes_ff[6]};
   assign front_out.desc.raw_w     = {bytes_ff[9], bytes_ff[8]};

endmodule

// ===== rtl/ifp_desc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_desc_queue - frame queue
// Short FIFO of checked frames between the assembler and the back end.
// ----------------------------------------------------------------------------
module ifp_desc_queue
   import ifp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type wdata,
   output logic     full,
   input  logic     pop,
   output desc_type rdata,
   output logic     empty
);

   localparam int PTR_W = $clog2(DESC_DEPTH);
   localparam int CNT_W = $clog2(DESC_DEPTH + 1);

   desc_type           mem_ff [DESC_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DESC_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DESC_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DESC_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/ifp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_back - scaling back end
// Holds the full-scale registers, scales axes and temperature in a two-stage
// pipeline (multiply, then format) and buffers finished words in a result FIFO.
// ----------------------------------------------------------------------------
module ifp_back
   import ifp_pkg::*;
#(
   parameter int RSP_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [SCALE_W-1:0]    csr_wdata,
   input  logic                  desc_empty,
   input  desc_type              desc,
   output logic                  desc_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output rsp_type               rsp
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   // full-scale registers
   logic [SCALE_W-1:0] accel_fs_ff, gyro_fs_ff, angle_fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_fs_ff <= ACCEL_FS_RESET;
         gyro_fs_ff  <= GYRO_FS_RESET;
         angle_fs_ff <= ANGLE_FS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ACCEL_FS: accel_fs_ff <= csr_wdata;
            CSR_GYRO_FS:  gyro_fs_ff  <= csr_wdata;
            CSR_ANGLE_FS: angle_fs_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: multiply
   logic                s1_v_ff;
   kind_type            s1_kind_ff;
   logic [7:0]          s1_type_ff;
   logic signed [44:0]  s1_px_ff, s1_py_ff, s1_pz_ff;
   logic [63:0]         s1_tprod_ff;
   logic                s1_tneg_ff;
   logic                s1_tvalid_ff;
   logic [15:0]         s1_ver_ff;

   logic [SCALE_W-1:0]  scale;
   logic [16:0]         temp_mag;
   logic [31:0]         temp_num;
   logic signed [SCALE_W:0] scale_s;

   always_comb begin
      unique case (desc.kind)
         KIND_ACCEL: scale = accel_fs_ff;
         KIND_GYRO:  scale = gyro_fs_ff;
         KIND_ANGLE: scale = angle_fs_ff;
         default:    scale = '0;
      endcase
   end

   assign scale_s  = $signed({1'b0, scale});
   // magnitude of the temperature word, then |raw| * 65536 + 50
   assign temp_mag = desc.raw_w[15] ? (~{desc.raw_w[15], desc.raw_w} + 17'd1)
                                    : {1'b0, desc.raw_w};
   assign temp_num = {temp_mag[15:0], 16'd50} | {temp_mag[16], 31'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= desc_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_pop) begin
         s1_kind_ff   <= desc.kind;
         s1_type_ff   <= desc.type_byte;
         s1_px_ff     <= $signed(desc.raw_x) * scale_s;
         s1_py_ff     <= $signed(desc.raw_y) * scale_s;
         s1_pz_ff     <= $signed(desc.raw_z) * scale_s;
         s1_tprod_ff  <= temp_num * TEMP_RECIP;
         s1_tneg_ff   <= desc.raw_w[15];
         s1_tvalid_ff <= (desc.kind == KIND_ACCEL) || (desc.kind == KIND_GYRO);
         s1_ver_ff    <= (desc.kind == KIND_ANGLE) ? desc.raw_w : 16'd0;
      end
   end

   // stage 2: floor shift of the axes, signed rounding of temperature
   logic              s2_v_ff;
   rsp_type           s2_rsp_ff, s2_rsp_in;
   logic [TEMP_W-1:0] temp_q;

   assign temp_q = s1_tprod_ff[TEMP_SHIFT +: TEMP_W];

   always_comb begin
      s2_rsp_in.kind         = s1_kind_ff;
      s2_rsp_in.type_byte    = s1_type_ff;
      s2_rsp_in.axis_x       = s1_px_ff[15 +: AXIS_W];
      s2_rsp_in.axis_y       = s1_py_ff[15 +: AXIS_W];
      s2_rsp_in.axis_z       = s1_pz_ff[15 +: AXIS_W];
      s2_rsp_in.temp_valid   = s1_tvalid_ff;
      s2_rsp_in.version_word = s1_ver_ff;
      if (!s1_tvalid_ff) begin
         s2_rsp_in.temperature = '0;
      end else if (s1_tneg_ff) begin
         s2_rsp_in.temperature = ~temp_q + 1'b1;
      end else begin
         s2_rsp_in.temperature = temp_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         s2_rsp_ff <= s2_rsp_in;
      end
   end

   // result FIFO
   rsp_type           mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W:0]    used;
   logic              do_pop;

   assign rsp_empty = (cnt_ff == '0);
   assign do_pop    = rsp_pop && !rsp_empty;
   assign rsp       = mem_ff[rd_ptr_ff];

   // take a frame only if its word is sure of a FIFO slot
   assign used     = (CNT_W+1)'(cnt_ff) + (CNT_W+1)'(s1_v_ff) + (CNT_W+1)'(s2_v_ff);
   assign desc_pop = !desc_empty && (used < (CNT_W+1)'(RSP_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (s2_v_ff) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (s2_v_ff && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !s2_v_ff) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_v_ff) begin
         mem_ff[wr_ptr_ff] <= s2_rsp_ff;
      end
   end

endmodule

// ===== rtl/imu_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser - serial IMU frame parser
// Assembles 11-byte sensor frames, checks the checksum and emits one scaled
// Q16.16 result word per good frame.
//
//   channel | direction | handshake         | payload
//   req_    | in        | push / full       | rx_byte
//   rsp_    | out       | empty / pop       | kind, type, axes, temp, version
//   csr_    | in        | we (no wait)      | addr, wdata (full-scale regs)
//
// One byte is taken every cycle; full rises only on a checksum byte while the
// frame queue is full. After its checksum byte a good frame's word passes
// through the queue, the multiply and the format stage to the result FIFO.
// Reset is synchronous and clears all counters and queues; no clearing pass.
// A stalled result side backs up through the result FIFO and frame queue
// before it ever holds off the byte input.
// ----------------------------------------------------------------------------
module imu_frame_parser
   import ifp_pkg::*;
#(
   parameter int RSP_DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   // bytes in
   input  logic                         req_push,
   input  logic [7:0]                   req_rx_byte,
   output logic                         req_full,
   // results out
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [1:0]                   rsp_frame_kind,
   output logic [7:0]                   rsp_type_byte,
   output logic signed [AXIS_W-1:0]     rsp_axis_x,
   output logic signed [AXIS_W-1:0]     rsp_axis_y,
   output logic signed [AXIS_W-1:0]     rsp_axis_z,
   output logic signed [TEMP_W-1:0]     rsp_temperature,
   output logic                         rsp_temp_valid,
   output logic [15:0]                  rsp_version_word,
   // configuration
   input  logic                         csr_we,
   input  logic [CSR_ADDR_W-1:0]        csr_addr,
   input  logic [SCALE_W-1:0]           csr_wdata
);

   front_out_type front_out;
   desc_type      desc;
   logic          desc_full;
   logic          desc_empty;
   logic          desc_pop;
   rsp_type       rsp;

   // front: frame assembly and checksum
   ifp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .desc_full   (desc_full),
      .front_out   (front_out)
   );

   // queue of checked frames
   ifp_desc_queue u_desc_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_out.push),
      .wdata (front_out.desc),
      .full  (desc_full),
      .pop   (desc_pop),
      .rdata (desc),
      .empty (desc_empty)
   );

   // back: scaling and result buffering
   ifp_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .desc_empty (desc_empty),
      .desc       (desc),
      .desc_pop   (desc_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp        (rsp)
   );

   assign rsp_frame_kind   = rsp.kind;
   assign rsp_type_byte    = rsp.type_byte;
   assign rsp_axis_x       = $signed(rsp.axis_x);
   assign rsp_axis_y       = $signed(rsp.axis_y);
   assign rsp_axis_z       = $signed(rsp.axis_z);
   assign rsp_temperature  = $signed(rsp.temperature);
   assign rsp_temp_valid   = rsp.temp_valid;
   assign rsp_version_word = rsp.version_word;

   // a good frame is never offered to a full frame queue
   assert property (@(posedge clock) disable iff (reset)
      front_out.push |-> !desc_full)
      else $error("frame pushed into full frame queue");

   // a pushed frame is waiting in the queue on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      front_out.push |=> !desc_empty)
      else $error("pushed frame missing from frame queue");

   // the byte input is held off only while frames are waiting
   assert property (@(posedge clock) disable iff (reset)
      req_full |-> !desc_empty)
      else $error("input stalled with empty frame queue");

endmodule
